/* design/aes_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aes_pkg
// Shared types, constants and byte functions of the AES-128 block cipher.
// ----------------------------------------------------------------------------
package aes_pkg;

  localparam int unsigned NumRounds = 10;

  localparam logic CmdEncrypt = 1'b0;
  localparam logic CmdDecrypt = 1'b1;

  localparam logic [0:0] RegKeyHigh = 1'b0;
  localparam logic [0:0] RegKeyLow  = 1'b1;

  typedef logic [127:0] block_t;
  typedef logic [7:0]   byte_t;

  // State and control that travel from one round cell to the next.
  typedef struct packed {
    logic   valid;
    logic   cmd;
    block_t state;
  } stage_t;

  localparam byte_t Rcon [NumRounds] = '{
    8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80, 8'h1b, 8'h36
  };

  localparam byte_t FwdBox [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  localparam byte_t InvBox [256] = '{
    8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
    8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
    8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
    8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
    8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
    8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
    8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
    8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
    8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
    8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
    8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
    8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
    8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
    8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
    8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
    8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
  };

  function automatic byte_t xt(input byte_t x);
    xt = {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
  endfunction

  // Byte i of the block sits in bits 127-8i downto 120-8i.
  function automatic byte_t get_byte(input block_t b, input int unsigned i);
    get_byte = b[127 - 8*i -: 8];
  endfunction

  // One forward round: SubBytes, ShiftRows, optional MixColumns.
  function automatic block_t enc_round(input block_t s, input logic mix);
    block_t t;
    block_t r;
    byte_t a0, a1, a2, a3;
    for (int i = 0; i < 16; i++) begin
      t[127 - 8*i -: 8] = FwdBox[get_byte(s, (i + 4*(i % 4)) % 16)];
    end
    r = t;
    if (mix) begin
      for (int c = 0; c < 4; c++) begin
        a0 = get_byte(t, 4*c); a1 = get_byte(t, 4*c+1);
        a2 = get_byte(t, 4*c+2); a3 = get_byte(t, 4*c+3);
        r[127 - 32*c -: 8]      = xt(a0) ^ xt(a1) ^ a1 ^ a2 ^ a3;
        r[127 - 32*c - 8 -: 8]  = a0 ^ xt(a1) ^ xt(a2) ^ a2 ^ a3;
        r[127 - 32*c - 16 -: 8] = a0 ^ a1 ^ xt(a2) ^ xt(a3) ^ a3;
        r[127 - 32*c - 24 -: 8] = xt(a0) ^ a0 ^ a1 ^ a2 ^ xt(a3);
      end
    end
    enc_round = r;
  endfunction

  // Inverse SubBytes and ShiftRows.
  function automatic block_t dec_sub(input block_t s);
    block_t t;
    for (int i = 0; i < 16; i++) begin
      t[127 - 8*i -: 8] = InvBox[get_byte(s, (i + 12*(i % 4)) % 16)];
    end
    dec_sub = t;
  endfunction

  function automatic block_t inv_mix(input block_t t);
    block_t r;
    byte_t a0, a1, a2, a3;
    byte_t x2 [4];
    byte_t x4 [4];
    byte_t x8 [4];
    byte_t a [4];
    for (int c = 0; c < 4; c++) begin
      for (int k = 0; k < 4; k++) begin
        a[k]  = get_byte(t, 4*c + k);
        x2[k] = xt(a[k]);
        x4[k] = xt(x2[k]);
        x8[k] = xt(x4[k]);
      end
      a0 = a[0]; a1 = a[1]; a2 = a[2]; a3 = a[3];
      // 14 = 8^4^2, 11 = 8^2^1, 13 = 8^4^1, 9 = 8^1.
      r[127 - 32*c -: 8] = (x8[0]^x4[0]^x2[0]) ^ (x8[1]^x2[1]^a1)
                         ^ (x8[2]^x4[2]^a2) ^ (x8[3]^a3);
      r[127 - 32*c - 8 -: 8] = (x8[0]^a0) ^ (x8[1]^x4[1]^x2[1])
                             ^ (x8[2]^x2[2]^a2) ^ (x8[3]^x4[3]^a3);
      r[127 - 32*c - 16 -: 8] = (x8[0]^x4[0]^a0) ^ (x8[1]^a1)
                              ^ (x8[2]^x4[2]^x2[2]) ^ (x8[3]^x2[3]^a3);
      r[127 - 32*c - 24 -: 8] = (x8[0]^x2[0]^a0) ^ (x8[1]^x4[1]^a1)
                              ^ (x8[2]^a2) ^ (x8[3]^x4[3]^x2[3]);
    end
    inv_mix = r;
  endfunction

  // One key expansion step from round key r-1 to round key r.
  function automatic block_t next_key(input block_t k, input byte_t rc);
    logic [31:0] w [4];
    logic [31:0] t;
    block_t r;
    for (int i = 0; i < 4; i++) w[i] = k[127 - 32*i -: 32];
    t = {FwdBox[w[3][23:16]] ^ rc, FwdBox[w[3][15:8]], FwdBox[w[3][7:0]],
         FwdBox[w[3][31:24]]};
    r[127:96] = w[0] ^ t;
    r[95:64]  = w[1] ^ r[127:96];
    r[63:32]  = w[2] ^ r[95:64];
    r[31:0]   = w[3] ^ r[63:32];
    next_key = r;
  endfunction

endpackage

/* design/aes128_block_cipher.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aes128_block_cipher
// AES-128 encrypt/decrypt engine with ten unrolled, registered round cells.
// ----------------------------------------------------------------------------
// Usage:
//   The slave stream takes one beat per block: tdata carries block_high in
//   bits 63:0 and block_low in bits 127:64, tuser carries cmd (0 encrypt,
//   1 decrypt). The master stream returns one beat per block with result_high
//   in bits 63:0 and result_low in bits 127:64, in input order.
//   The key is written over the APB port: key_high at address 0x0, key_low
//   at 0x8. The round keys are then derived one per cycle in the key
//   schedule, so s_tready stays low after each key write and after reset
//   until they settle. Keys are to be written by the user only while no
//   block is in flight; the cipher does not enforce this. A beat passes
//   one input stage adding the first round key, then ten round cells. The
//   chain accepts one block per cycle, back to back, unless full or busy.
//   When the receiver stalls, the last cell holds its result and the stages
//   behind it keep moving until they meet a full stage, so bubbles are
//   squeezed out; s_tready falls only once every stage is full, and no beat
//   is lost. Reset clears the keys to zero and empties the chain.
// ----------------------------------------------------------------------------
module aes128_block_cipher (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  output logic          s_tready,
  input  logic [127:0]  s_tdata,   // block_high[63:0], block_low[127:64]
  input  logic [0:0]    s_tuser,   // cmd
  output logic          m_tvalid,
  input  logic          m_tready,
  output logic [127:0]  m_tdata,   // result_high[63:0], result_low[127:64]
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [3:0]    paddr,
  input  logic [63:0]   pwdata,
  output logic [63:0]   prdata,
  output logic          pready
);

  localparam int unsigned N = aes_pkg::NumRounds;

  logic [63:0]     key_high;
  logic [63:0]     key_low;
  logic            key_busy;
  aes_pkg::block_t round_keys [N + 1];
  logic            cfg_wr;
  aes_pkg::stage_t in_stage;
  aes_pkg::stage_t stage [N + 1];
  logic [N:0]      adv;

  assign pready = 1'b1;
  // The register is selected by address bit 3 alone.
  assign cfg_wr = psel && penable && pwrite;

  always_comb begin
    unique case (paddr[3:3])
      aes_pkg::RegKeyHigh: prdata = key_high;
      aes_pkg::RegKeyLow:  prdata = key_low;
      default:             prdata = '0;
    endcase
  end

  aes_key_sched u_keys (
    .clk, .rst,
    .wr_en(cfg_wr), .wr_idx(paddr[3:3]), .wr_data(pwdata),
    .key_high, .key_low, .key_busy, .round_keys
  );

  // A stage may move on when the stage after it moves or is empty.
  always_comb begin
    adv[N] = m_tready || !stage[N].valid;
    for (int i = N - 1; i >= 0; i--) adv[i] = adv[i+1] || !stage[i].valid;
  end

  // New blocks wait while the round keys settle after a key write.
  assign s_tready = adv[0] && !key_busy && !cfg_wr;

  // Input stage: initial AddRoundKey, round key 0 or 10 by direction.
  always_ff @(posedge clk) begin
    if (adv[0]) begin
      in_stage.cmd   <= s_tuser[0];
      in_stage.state <= {s_tdata[63:0], s_tdata[127:64]}
                        ^ ((s_tuser[0] == aes_pkg::CmdDecrypt) ? round_keys[N] : round_keys[0]);
    end
    if (rst) begin
      in_stage.valid <= 1'b0;
    end else if (adv[0]) begin
      in_stage.valid <= s_tvalid && s_tready;
    end
  end

  assign stage[0] = in_stage;

  for (genvar r = 1; r <= N; r++) begin : g_round
    aes_round_cell #(.LastRound(r == N)) u_cell (
      .clk, .rst,
      .en(adv[r]),
      .din(stage[r-1]),
      .enc_key(round_keys[r]),
      .dec_key(round_keys[N - r]),
      .dout(stage[r])
    );
  end

  assign m_tvalid = stage[N].valid;
  assign m_tdata  = {stage[N].state[63:0], stage[N].state[127:64]};

endmodule

/* design/aes_key_sched.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aes_key_sched
// Holds the key registers and the eleven expanded round keys.
// ----------------------------------------------------------------------------
module aes_key_sched (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   wr_en,
  input  logic [0:0]             wr_idx,
  input  logic [63:0]            wr_data,
  output logic [63:0]            key_high,
  output logic [63:0]            key_low,
  output logic                   key_busy,
  output aes_pkg::block_t        round_keys [aes_pkg::NumRounds + 1]
);

  logic [3:0] busy_cnt;

  // Round key r is derived one step per cycle after a key write, in a register
  // fed from round key r-1. The busy count covers that settling time, and
  // also the settling of the reset key.
  always_ff @(posedge clk) begin
    if (rst) begin
      key_high <= '0;
      key_low  <= '0;
      busy_cnt <= 4'(aes_pkg::NumRounds);
    end else if (wr_en) begin
      if (wr_idx == aes_pkg::RegKeyHigh) key_high <= wr_data;
      else                               key_low  <= wr_data;
      busy_cnt <= 4'(aes_pkg::NumRounds);
    end else if (busy_cnt != 4'd0) begin
      busy_cnt <= busy_cnt - 4'd1;
    end
  end

  assign key_busy = (busy_cnt != 4'd0);

  assign round_keys[0] = {key_high, key_low};

  for (genvar r = 1; r <= aes_pkg::NumRounds; r++) begin : g_key
    aes_pkg::block_t rk;
    always_ff @(posedge clk) begin
      rk <= aes_pkg::next_key(round_keys[r-1], aes_pkg::Rcon[r-1]);
    end
    assign round_keys[r] = rk;
  end

endmodule

/* design/aes_round_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aes_round_cell
// One registered round of the cipher, shared shape for encrypt and decrypt.
// ----------------------------------------------------------------------------
module aes_round_cell #(
  parameter bit LastRound = 1'b0
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  aes_pkg::stage_t  din,
  input  aes_pkg::block_t  enc_key,
  input  aes_pkg::block_t  dec_key,
  output aes_pkg::stage_t  dout
);

  aes_pkg::block_t enc_s;
  aes_pkg::block_t dec_s;
  aes_pkg::block_t dec_k;

  always_comb begin
    enc_s = aes_pkg::enc_round(din.state, !LastRound) ^ enc_key;
    dec_k = aes_pkg::dec_sub(din.state) ^ dec_key;
    dec_s = LastRound ? dec_k : aes_pkg::inv_mix(dec_k);
  end

  // Only the valid bit is reset; the data simply follows it.
  always_ff @(posedge clk) begin
    if (en) begin
      dout.cmd   <= din.cmd;
      dout.state <= (din.cmd == aes_pkg::CmdDecrypt) ? dec_s : enc_s;
    end
    if (rst) begin
      dout.valid <= 1'b0;
    end else if (en) begin
      dout.valid <= din.valid;
    end
  end

endmodule

/* design/aes128_block_cipher_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aes128_block_cipher_checker
// Port-level checks of the cipher's streams, bound to the top level.
// ----------------------------------------------------------------------------
module aes128_block_cipher_checker (
  input logic         clk,
  input logic         rst,
  input logic         s_tready,
  input logic         m_tvalid,
  input logic         m_tready,
  input logic [127:0] m_tdata,
  input logic         pready
);

  // A result held under stall keeps its data.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed under stall");

  // A result beat always carries known data.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !$isunknown(m_tdata))
    else $error("unknown result data");

  // The input waits for the reset key schedule to settle.
  assert property (@(posedge clk) $fell(rst) |-> !s_tready)
    else $error("input ready straight after reset");

  // Nothing comes out straight after reset.
  assert property (@(posedge clk) $fell(rst) |-> !m_tvalid)
    else $error("result after reset");

  assert property (@(posedge clk) pready)
    else $error("pready low");

endmodule

bind aes128_block_cipher aes128_block_cipher_checker u_checker (
  .clk, .rst, .s_tready, .m_tvalid, .m_tready, .m_tdata, .pready
);

/* test/aes128_block_cipher_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aes128_block_cipher_tb
// Self-checking bench for the AES-128 engine: every block sent on the slave
// stream is ciphered by a behavioural AES model in the bench, and the result
// beats on the master stream are compared in order with the predicted blocks.
// ----------------------------------------------------------------------------
module aes128_block_cipher_tb;

  logic          clk = 1'b0;
  logic          rst = 1'b1;
  logic          s_tvalid = 1'b0;
  logic          s_tready;
  logic [127:0]  s_tdata = '0;
  logic [0:0]    s_tuser = '0;
  logic          m_tvalid;
  logic          m_tready = 1'b0;
  logic [127:0]  m_tdata;
  logic          psel = 1'b0;
  logic          penable = 1'b0;
  logic          pwrite = 1'b0;
  logic [3:0]    paddr = '0;
  logic [63:0]   pwdata = '0;
  logic [63:0]   prdata;
  logic          pready;

  aes128_block_cipher i_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #1 clk = ~clk;

  // The bench's S-box tables, copied from the package as byte arrays.
  logic [7:0] sbox_f [256];
  logic [7:0] sbox_i [256];
  logic [7:0] rcon_tab [10];

  logic [127:0] cur_key = '0;      // key as the bench believes it stands
  logic [127:0] cipher_q [$];      // predicted result blocks, oldest first
  int           err_cnt = 0;
  bit           sink_gaps = 1'b1;  // random stalls on the master side
  bit           src_gaps = 1'b1;   // random gaps on the slave side
  int           hold_cycles = 0;   // long stall requested of the receiver

  function automatic logic [7:0] dbl(input logic [7:0] x);
    return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] gmul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] acc;
    acc = 8'h00;
    for (int k = 0; k < 8; k++) begin
      if (b[k]) acc ^= a;
      a = dbl(a);
    end
    return acc;
  endfunction

  // Full AES-128 on byte arrays; byte 0 is the most significant of the block.
  function automatic logic [127:0] aes_cipher(input logic [127:0] key,
                                              input logic [127:0] blk,
                                              input logic dec);
    logic [7:0] w [176];
    logic [7:0] s [16];
    logic [7:0] t [16];
    logic [7:0] tw [4];
    logic [7:0] f, a0, a1, a2, a3;
    logic [127:0] r;
    for (int i = 0; i < 16; i++) begin
      w[i] = key[127-8*i -: 8];
      s[i] = blk[127-8*i -: 8];
    end
    for (int i = 4; i < 44; i++) begin
      for (int j = 0; j < 4; j++) tw[j] = w[(i-1)*4+j];
      if (i % 4 == 0) begin
        f = tw[0];
        tw[0] = sbox_f[tw[1]] ^ rcon_tab[i/4-1];
        tw[1] = sbox_f[tw[2]];
        tw[2] = sbox_f[tw[3]];
        tw[3] = sbox_f[f];
      end
      for (int j = 0; j < 4; j++) w[i*4+j] = w[(i-4)*4+j] ^ tw[j];
    end
    if (!dec) begin
      for (int i = 0; i < 16; i++) s[i] ^= w[i];
      for (int rn = 1; rn <= 10; rn++) begin
        for (int i = 0; i < 16; i++) t[i] = sbox_f[s[(i + 4*(i%4)) % 16]];
        if (rn < 10) begin
          for (int c = 0; c < 4; c++) begin
            a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
            t[4*c]   = dbl(a0) ^ dbl(a1) ^ a1 ^ a2 ^ a3;
            t[4*c+1] = a0 ^ dbl(a1) ^ dbl(a2) ^ a2 ^ a3;
            t[4*c+2] = a0 ^ a1 ^ dbl(a2) ^ dbl(a3) ^ a3;
            t[4*c+3] = dbl(a0) ^ a0 ^ a1 ^ a2 ^ dbl(a3);
          end
        end
        for (int i = 0; i < 16; i++) s[i] = t[i] ^ w[rn*16+i];
      end
    end else begin
      for (int i = 0; i < 16; i++) s[i] ^= w[160+i];
      for (int rn = 9; rn >= 0; rn--) begin
        for (int i = 0; i < 16; i++) t[i] = sbox_i[s[(i + 12*(i%4)) % 16]] ^ w[rn*16+i];
        if (rn > 0) begin
          for (int c = 0; c < 4; c++) begin
            a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
            t[4*c]   = gmul(a0,14) ^ gmul(a1,11) ^ gmul(a2,13) ^ gmul(a3,9);
            t[4*c+1] = gmul(a0,9) ^ gmul(a1,14) ^ gmul(a2,11) ^ gmul(a3,13);
            t[4*c+2] = gmul(a0,13) ^ gmul(a1,9) ^ gmul(a2,14) ^ gmul(a3,11);
            t[4*c+3] = gmul(a0,11) ^ gmul(a1,13) ^ gmul(a2,9) ^ gmul(a3,14);
          end
        end
        for (int i = 0; i < 16; i++) s[i] = t[i];
      end
    end
    for (int i = 0; i < 16; i++) r[127-8*i -: 8] = s[i];
    return r;
  endfunction

  function automatic logic [63:0] rand64();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      default: return {$urandom(), $urandom()};
    endcase
  endfunction

  // One APB write: setup cycle, then access cycle; pready is always high.
  task automatic apb_write(input logic [0:0] reg_sel, input logic [63:0] value);
    @(negedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {reg_sel, 3'b000}; pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (reg_sel == aes_pkg::RegKeyHigh) cur_key[127:64] = value;
    else cur_key[63:0] = value;
  endtask

  // Waits until the pipe is empty, then loads a new key and lets the
  // schedule settle before any block is sent.
  task automatic load_key(input logic [127:0] key);
    while (cipher_q.size() != 0) @(posedge clk);
    repeat (14) @(posedge clk);
    apb_write(aes_pkg::RegKeyHigh, key[127:64]);
    apb_write(aes_pkg::RegKeyLow, key[63:0]);
    repeat (14) @(posedge clk);
  endtask

  // Sends one block beat; the prediction is queued as it is accepted.
  task automatic send_block(input logic cmd, input logic [127:0] blk);
    if (src_gaps && $urandom_range(0, 3) == 0) repeat ($urandom_range(1, 7)) @(negedge clk);
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tdata  <= {blk[63:0], blk[127:64]};
    s_tuser  <= cmd;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    cipher_q.push_back(aes_cipher(cur_key, blk, cmd));
    @(negedge clk);
    s_tvalid <= 1'b0;
  endtask

  // Back-to-back sending: valid stays high between beats.
  task automatic send_burst(input int n);
    logic cmd;
    logic [127:0] blk;
    @(negedge clk);
    for (int i = 0; i < n; i++) begin
      cmd = 1'($urandom_range(0, 1));
      blk = {rand64(), rand64()};
      s_tvalid <= 1'b1;
      s_tdata  <= {blk[63:0], blk[127:64]};
      s_tuser  <= cmd;
      @(posedge clk);
      while (!s_tready) @(posedge clk);
      cipher_q.push_back(aes_cipher(cur_key, blk, cmd));
      @(negedge clk);
    end
    s_tvalid <= 1'b0;
  endtask

  // Receiver readiness: random stall bursts, or a long counted hold-off.
  initial begin
    int gap;
    @(negedge clk);
    m_tready <= 1'b1;
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        m_tready <= 1'b0;
        hold_cycles--;
      end else if (sink_gaps && $urandom_range(0, 5) == 0) begin
        m_tready <= 1'b0;
        gap = $urandom_range(1, 7);
        repeat (gap - 1) @(negedge clk);
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // Result checker: every accepted result beat against the oldest prediction.
  always @(posedge clk) begin
    logic [127:0] want;
    if (!rst && m_tvalid && m_tready) begin
      if (cipher_q.size() == 0) begin
        err_cnt++;
        if (err_cnt <= 10) $display("Unexpected result beat %h", m_tdata);
      end else begin
        want = cipher_q.pop_front();
        if (m_tdata[63:0] !== want[127:64] || m_tdata[127:64] !== want[63:0]) begin
          err_cnt++;
          if (err_cnt <= 10) $display("Result mismatch: expected %h, got %h", want,
                                      {m_tdata[63:0], m_tdata[127:64]});
        end
      end
    end
  end

  // Known-answer vectors and field extremes.
  task automatic test_directed();
    logic [127:0] k;
    // Published AES-128 vector, both directions.
    load_key(128'h000102030405060708090a0b0c0d0e0f);
    send_block(aes_pkg::CmdEncrypt, 128'h00112233445566778899aabbccddeeff);
    send_block(aes_pkg::CmdDecrypt, 128'h69c4e0d86a7b0430d8cdb78070b4c55a);
    // Reset key is all zero; now the all-zero and all-one extremes.
    load_key('0);
    send_block(aes_pkg::CmdEncrypt, '0);
    send_block(aes_pkg::CmdEncrypt, '1);
    send_block(aes_pkg::CmdDecrypt, '0);
    send_block(aes_pkg::CmdDecrypt, '1);
    load_key('1);
    send_block(aes_pkg::CmdEncrypt, '0);
    send_block(aes_pkg::CmdEncrypt, '1);
    send_block(aes_pkg::CmdDecrypt, '0);
    send_block(aes_pkg::CmdDecrypt, '1);
    k = {rand64(), rand64()};
    load_key(k);
    for (int i = 0; i < 8; i++) send_block(1'(i % 2), {rand64(), rand64()});
  endtask

  // Random blocks across several random keys, with gaps on both sides.
  task automatic test_random_keys();
    for (int p = 0; p < 8; p++) begin
      load_key({rand64(), rand64()});
      for (int i = 0; i < 120; i++) send_block(1'($urandom_range(0, 1)), {rand64(), rand64()});
    end
  endtask

  // The receiver holds off long enough that the chain fills and s_tready
  // falls, while the sender keeps offering beats.
  task automatic test_backpressure();
    load_key({rand64(), rand64()});
    hold_cycles = 60;
    send_burst(80);
    // Sender pauses until every predicted result has come back.
    while (cipher_q.size() != 0) @(posedge clk);
    send_burst(40);
  endtask

  // Last part: full rate on both sides, no idling.
  task automatic test_full_rate();
    load_key({rand64(), rand64()});
    src_gaps = 1'b0;
    sink_gaps = 1'b0;
    send_burst(350);
  endtask

  initial begin
    sbox_f = aes_pkg::FwdBox;
    sbox_i = aes_pkg::InvBox;
    rcon_tab = aes_pkg::Rcon;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_random_keys();
    test_backpressure();
    test_full_rate();
    while (cipher_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (err_cnt == 0 && cipher_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Watchdog far beyond the slowest correct run.
  initial begin
    #400000;
    $display("Some tests failed");
    $finish;
  end

endmodule
